// ----- design/jts_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// JSON token serializer package
// Transaction types, token kind codes and output segment numbering.
// ---------------------------------------------------------------------------
package jts_pkg;

  localparam logic [3:0] K_BOBJ = 4'd0;
  localparam logic [3:0] K_EOBJ = 4'd1;
  localparam logic [3:0] K_BARR = 4'd2;
  localparam logic [3:0] K_EARR = 4'd3;
  localparam logic [3:0] K_KEY  = 4'd4;
  localparam logic [3:0] K_STR  = 4'd5;
  localparam logic [3:0] K_UINT = 4'd6;
  localparam logic [3:0] K_SINT = 4'd7;
  localparam logic [3:0] K_BOOL = 4'd8;
  localparam logic [3:0] K_NULL = 4'd9;
  localparam logic [3:0] K_HEX  = 4'd10;

  localparam int SEG_COMMA = 0;
  localparam int SEG_NL    = 1;
  localparam int SEG_IND   = 2;
  localparam int SEG_LEAD  = 3;
  localparam int SEG_BODY  = 4;
  localparam int SEG_DEC   = 5;
  localparam int SEG_TAIL  = 6;
  localparam int SEG_COLON = 7;
  localparam int SEG_SPACE = 8;
  localparam int NSEG      = 9;

  localparam int NDIG     = 20;
  localparam int NUM_BITS = 64;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  char_byte;
    logic [63:0] number;
    logic        first_piece;
    logic        last_piece;
    logic        empty_run;
    logic        upper_hex;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       fail_flag;
  } out_item_t;

endpackage
`default_nettype wire

// ----- design/json_token_serializer_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// JSON token serializer unit
// Turns a stream of JSON tokens into the bytes of the JSON text.
// ---------------------------------------------------------------------------
// One token is taken per input transaction when in_valid is high and in_stall
// is low. Each token yields zero or more output transactions, one byte each;
// run_end marks the last byte of a token and fail_flag shows the sticky
// failure state after that token. cfg_wr_data selects pretty printing; the
// user must see that it is written only while the unit is idle, as the
// unit itself does not enforce this. A token is decoded when it is taken and
// then occupies the unit while its bytes are emitted, one byte per cycle
// while out_stall is low. Decimal tokens first run a shift-and-add-3 binary
// to BCD conversion, then strip leading zeros, before their digits go out.
// No new token is taken until the last byte of the current one is emitted.
// The output register holds its byte while out_stall is high and the
// sequencer waits with it; no byte is lost or repeated.
// Reset empties the nesting stack, clears the failure, root and key state
// and selects compact output.
// ---------------------------------------------------------------------------
module json_token_serializer_unit #(
  parameter int MAX_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  jts_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output jts_pkg::out_item_t  out_item,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data
);
  import jts_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(2 * MAX_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DW-1:0]       depth_r;
  logic [MAX_DEPTH-1:0] lvl_arr_r, lvl_first_r;
  logic                key_r, root_r, failed_r, pretty_r;
  logic [NSEG-1:0]     mask_r, mask_nxt;
  logic [7:0]          lead_r;
  logic [47:0]         body_r;
  logic [2:0]          body_cnt_r;
  logic [CW-1:0]       ind_cnt_r;
  logic [4*NDIG-1:0]   bcd_r;
  logic [NUM_BITS-1:0] bin_r;
  logic [6:0]          conv_cnt_r;
  logic [4:0]          dig_cnt_r;
  logic                out_valid_r;
  out_item_t           out_r;

  function automatic logic [7:0] hex_digit(input logic [3:0] v, input logic upper);
    if (v < 4'd10) begin
      hex_digit = 8'h30 + {4'h0, v};
    end else begin
      hex_digit = (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
    end
  endfunction

  logic            accept, depth0, top_arr, top_first, is_a, start, ok, go;
  logic [IW-1:0]   top_idx, push_idx;
  logic            bv_ok, bv_fail, bv_arr, kb_ok, kb_fail;
  logic            fail_set, root_set, key_set, key_clr, push, pop, first_clr;
  logic [NSEG-1:0] mask_a;
  logic [7:0]      lead_a;
  logic [47:0]     body_a;
  logic [2:0]      body_n;
  logic [CW-1:0]   ind_n;
  logic [NUM_BITS-1:0] mag;
  logic [7:0]      ch;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign depth0    = (depth_r == '0);
  assign top_idx   = IW'(depth_r - DW'(1));
  assign push_idx  = IW'(depth_r);
  assign top_arr   = lvl_arr_r[top_idx];
  assign top_first = lvl_first_r[top_idx];
  assign ch        = in_item.char_byte;

  assign bv_ok   = !failed_r && (depth0 ? !root_r : (top_arr || key_r));
  assign bv_fail = !failed_r && (depth0 ? root_r : (!top_arr && !key_r));
  assign bv_arr  = !failed_r && !depth0 && top_arr;
  assign kb_ok   = !failed_r && !depth0 && !top_arr && !key_r;
  assign kb_fail = !failed_r && (depth0 || top_arr || key_r);

  always_comb begin
    fail_set  = 1'b0;
    root_set  = 1'b0;
    key_set   = 1'b0;
    key_clr   = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    first_clr = 1'b0;
    mask_a    = '0;
    lead_a    = 8'h22;
    body_a    = '0;
    body_n    = 3'd0;
    ind_n     = CW'(depth_r) << 1;
    mag       = in_item.number;
    is_a      = (in_item.kind == K_BARR) || (in_item.kind == K_EARR);
    start     = in_item.empty_run || in_item.first_piece;
    ok        = (in_item.kind == K_KEY) ? kb_ok : bv_ok;
    go        = start ? ok : !failed_r;
    case (in_item.kind)
      K_BOBJ, K_BARR: begin
        if (bv_ok) begin
          root_set           = depth0;
          key_clr            = !depth0 && !top_arr;
          first_clr          = bv_arr;
          mask_a[SEG_COMMA]  = bv_arr && !top_first;
          mask_a[SEG_NL]     = bv_arr && pretty_r;
          mask_a[SEG_IND]    = bv_arr && pretty_r;
          mask_a[SEG_LEAD]   = 1'b1;
          lead_a             = is_a ? 8'h5B : 8'h7B;
          if (depth_r >= DW'(MAX_DEPTH)) begin
            fail_set = 1'b1;
          end else begin
            push = 1'b1;
          end
        end else begin
          fail_set = bv_fail;
        end
      end
      K_EOBJ, K_EARR: begin
        if (depth0 || (top_arr != is_a) || (!is_a && key_r)) begin
          fail_set = 1'b1;
        end else begin
          ind_n            = CW'(depth_r - DW'(1)) << 1;
          mask_a[SEG_NL]   = pretty_r && !top_first;
          mask_a[SEG_IND]  = pretty_r && !top_first && (ind_n != '0);
          mask_a[SEG_LEAD] = 1'b1;
          lead_a           = is_a ? 8'h5D : 8'h7D;
          pop              = 1'b1;
          key_clr          = 1'b1;
        end
      end
      K_KEY, K_STR, K_HEX: begin
        if (start && !ok) begin
          fail_set = (in_item.kind == K_KEY) ? kb_fail : bv_fail;
        end
        if (go) begin
          if (start) begin
            mask_a[SEG_LEAD] = 1'b1;
            if (in_item.kind == K_KEY) begin
              key_set           = 1'b1;
              first_clr         = 1'b1;
              mask_a[SEG_COMMA] = !top_first;
              mask_a[SEG_NL]    = pretty_r;
              mask_a[SEG_IND]   = pretty_r;
            end else begin
              root_set          = depth0;
              key_clr           = !depth0 && !top_arr;
              first_clr         = bv_arr;
              mask_a[SEG_COMMA] = bv_arr && !top_first;
              mask_a[SEG_NL]    = bv_arr && pretty_r;
              mask_a[SEG_IND]   = bv_arr && pretty_r;
            end
          end
          if (!in_item.empty_run) begin
            mask_a[SEG_BODY] = 1'b1;
            if (in_item.kind == K_HEX) begin
              body_a = {hex_digit(ch[7:4], in_item.upper_hex),
                        hex_digit(ch[3:0], in_item.upper_hex), 32'h0};
              body_n = 3'd2;
            end else begin
              case (ch)
                8'h22:   begin body_a = {8'h5C, 8'h22, 32'h0}; body_n = 3'd2; end
                8'h5C:   begin body_a = {8'h5C, 8'h5C, 32'h0}; body_n = 3'd2; end
                8'h08:   begin body_a = {8'h5C, 8'h62, 32'h0}; body_n = 3'd2; end
                8'h0C:   begin body_a = {8'h5C, 8'h66, 32'h0}; body_n = 3'd2; end
                8'h0A:   begin body_a = {8'h5C, 8'h6E, 32'h0}; body_n = 3'd2; end
                8'h0D:   begin body_a = {8'h5C, 8'h72, 32'h0}; body_n = 3'd2; end
                8'h09:   begin body_a = {8'h5C, 8'h74, 32'h0}; body_n = 3'd2; end
                default: begin
                  if (ch < 8'h20) begin
                    body_a = {8'h5C, 8'h75, 8'h30, 8'h30,
                              hex_digit(ch[7:4], 1'b1), hex_digit(ch[3:0], 1'b1)};
                    body_n = 3'd6;
                  end else begin
                    body_a = {ch, 40'h0};
                    body_n = 3'd1;
                  end
                end
              endcase
            end
          end
          if (in_item.empty_run || in_item.last_piece) begin
            mask_a[SEG_TAIL]  = 1'b1;
            mask_a[SEG_COLON] = (in_item.kind == K_KEY);
            mask_a[SEG_SPACE] = (in_item.kind == K_KEY) && pretty_r;
          end
        end
      end
      K_UINT, K_SINT, K_BOOL, K_NULL: begin
        if (bv_ok) begin
          root_set          = depth0;
          key_clr           = !depth0 && !top_arr;
          first_clr         = bv_arr;
          mask_a[SEG_COMMA] = bv_arr && !top_first;
          mask_a[SEG_NL]    = bv_arr && pretty_r;
          mask_a[SEG_IND]   = bv_arr && pretty_r;
          if (in_item.kind == K_UINT || in_item.kind == K_SINT) begin
            mask_a[SEG_DEC] = 1'b1;
            if (in_item.kind == K_SINT && in_item.number[NUM_BITS-1]) begin
              mask_a[SEG_LEAD] = 1'b1;
              lead_a           = 8'h2D;
              mag              = ~in_item.number + NUM_BITS'(1);
            end
          end else begin
            mask_a[SEG_BODY] = 1'b1;
            if (in_item.kind == K_NULL) begin
              body_a = {"null", 16'h0};
              body_n = 3'd4;
            end else if (in_item.number != '0) begin
              body_a = {"true", 16'h0};
              body_n = 3'd4;
            end else begin
              body_a = {"false", 8'h0};
              body_n = 3'd5;
            end
          end
        end else begin
          fail_set = bv_fail;
        end
      end
      default: begin
      end
    endcase
  end

  // Emission of one byte from the lowest pending segment
  logic [NSEG-1:0] cur;
  logic            can_emit, seg_done;
  logic [7:0]      emit_b;
  logic [4*NDIG-1:0] bcd_adj;

  assign cur      = mask_r & (~mask_r + NSEG'(1));
  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    emit_b   = 8'h20;
    seg_done = 1'b1;
    if (cur[SEG_COMMA]) begin
      emit_b = 8'h2C;
    end else if (cur[SEG_NL]) begin
      emit_b = 8'h0A;
    end else if (cur[SEG_IND]) begin
      emit_b   = 8'h20;
      seg_done = (ind_cnt_r == CW'(1));
    end else if (cur[SEG_LEAD]) begin
      emit_b = lead_r;
    end else if (cur[SEG_BODY]) begin
      emit_b   = body_r[47:40];
      seg_done = (body_cnt_r == 3'd1);
    end else if (cur[SEG_DEC]) begin
      emit_b   = {4'h3, bcd_r[4*NDIG-1 -: 4]};
      seg_done = (dig_cnt_r == 5'd1);
    end else if (cur[SEG_TAIL]) begin
      emit_b = 8'h22;
    end else if (cur[SEG_COLON]) begin
      emit_b = 8'h3A;
    end
  end

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mask_nxt = mask_a;
          if (mask_a[SEG_DEC]) begin
            state_nxt = ST_CONV;
          end else if (mask_a != '0) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        if (conv_cnt_r == 7'd1) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (dig_cnt_r == 5'd1 || bcd_r[4*NDIG-1 -: 4] != 4'h0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_emit && seg_done) begin
          mask_nxt = mask_r & ~cur;
          if ((mask_r & ~cur) == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= '0;
      depth_r     <= '0;
      key_r       <= 1'b0;
      root_r      <= 1'b0;
      failed_r    <= 1'b0;
      pretty_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      if (cfg_wr_en) begin
        pretty_r <= cfg_wr_data;
      end
      if (accept) begin
        if (push) begin
          depth_r <= depth_r + DW'(1);
        end else if (pop) begin
          depth_r <= depth_r - DW'(1);
        end
        if (key_set) begin
          key_r <= 1'b1;
        end else if (key_clr || push) begin
          key_r <= 1'b0;
        end
        if (root_set) begin
          root_r <= 1'b1;
        end
        if (fail_set) begin
          failed_r <= 1'b1;
        end
      end
      if (state_r == ST_EMIT && can_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (accept && push && push_idx == IW'(i)) begin
        lvl_arr_r[i]   <= is_a;
        lvl_first_r[i] <= 1'b1;
      end else if (accept && first_clr && top_idx == IW'(i)) begin
        lvl_first_r[i] <= 1'b0;
      end
    end
    if (accept) begin
      lead_r     <= lead_a;
      body_r     <= body_a;
      body_cnt_r <= body_n;
      ind_cnt_r  <= ind_n;
      bin_r      <= mag;
      bcd_r      <= '0;
      conv_cnt_r <= 7'(NUM_BITS);
      dig_cnt_r  <= 5'(NDIG);
    end else if (state_r == ST_CONV) begin
      bcd_r      <= {bcd_adj[4*NDIG-2:0], bin_r[NUM_BITS-1]};
      bin_r      <= bin_r << 1;
      conv_cnt_r <= conv_cnt_r - 7'd1;
    end else if (state_r == ST_SKIP) begin
      if (dig_cnt_r != 5'd1 && bcd_r[4*NDIG-1 -: 4] == 4'h0) begin
        bcd_r     <= bcd_r << 4;
        dig_cnt_r <= dig_cnt_r - 5'd1;
      end
    end else if (state_r == ST_EMIT && can_emit) begin
      out_r.out_byte  <= emit_b;
      out_r.run_end   <= seg_done && ((mask_r & ~cur) == '0);
      out_r.fail_flag <= failed_r;
      if (cur[SEG_IND]) begin
        ind_cnt_r <= ind_cnt_r - CW'(1);
      end
      if (cur[SEG_BODY]) begin
        body_r     <= body_r << 8;
        body_cnt_r <= body_cnt_r - 3'd1;
      end
      if (cur[SEG_DEC]) begin
        bcd_r     <= bcd_r << 4;
        dig_cnt_r <= dig_cnt_r - 5'd1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("nesting depth beyond its limit");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("failure flag cleared without reset");

  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (mask_r != '0))
    else $error("emitting with no segment pending");

endmodule
`default_nettype wire
